// ===== rtl/core/bdc_pkg.sv =====
// shared constants, codes and types of the block duplicate checker
package bdc_pkg;

	// map geometry
	localparam int MAX_BLOCKS = 65536;
	localparam int ROW_BITS   = 32;
	localparam int BIT_AW     = $clog2(ROW_BITS);
	localparam int ROWS       = MAX_BLOCKS / ROW_BITS;
	localparam int ROW_AW     = $clog2(ROWS);

	// field widths
	localparam int BLK_W = 16;
	localparam int FS_W  = 17;
	localparam int CNT_W = 16;
	localparam int SUM_W = $clog2(MAX_BLOCKS + 1);

	localparam logic [FS_W-1:0]  BLK_LIMIT = FS_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] CNT_SAT   = '1;

	// register port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_W  = ADDR_W - 2;

	localparam logic [REG_W-1:0] REG_FIRST   = 3'd0;
	localparam logic [REG_W-1:0] REG_FS_SIZE = 3'd1;
	localparam logic [REG_W-1:0] REG_WATCH_A = 3'd2;
	localparam logic [REG_W-1:0] REG_WATCH_B = 3'd3;
	localparam logic [REG_W-1:0] REG_WATCH_C = 3'd4;
	localparam logic [REG_W-1:0] REG_WATCH_D = 3'd5;

	localparam logic [BLK_W-1:0] FIRST_RST   = 16'd2;
	localparam logic [FS_W-1:0]  FS_SIZE_RST = 17'h10000;

	// request codes
	localparam logic [1:0] REQ_CHECK = 2'd0;
	localparam logic [1:0] REQ_SWEEP = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_OOR  = 2'd1;
	localparam logic [1:0] STAT_DUP  = 2'd2;
	localparam logic [1:0] STAT_DONE = 2'd3;

	// request queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// classified request as it waits in the queue
	typedef struct packed {
		logic [1:0]       req;
		logic [BLK_W-1:0] blk;
		logic             inode;
		logic             in_range;
		logic             hit;
	} item_t;

	// range settings used by the back end
	typedef struct packed {
		logic [BLK_W-1:0] first_data_block;
		logic [FS_W-1:0]  fs_size;
	} cfg_t;

endpackage

// ===== rtl/core/bdc_front.sv =====
// front end: register file, request classification and range/watch checks
module bdc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bdc_pkg::DATA_W-1:0]  pwdata,
	output logic [bdc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [bdc_pkg::BLK_W-1:0]   block_number,
	input  logic                        from_inode,
	input  logic                        q_full,
	input  logic                        init_busy,
	output logic                        q_push,
	output bdc_pkg::item_t              q_item,
	output bdc_pkg::cfg_t               cfg
);
	import bdc_pkg::*;

	logic [BLK_W-1:0] first_q;
	logic [FS_W-1:0]  fs_size_q;
	logic [BLK_W-1:0] watch_a_q;
	logic [BLK_W-1:0] watch_b_q;
	logic [BLK_W-1:0] watch_c_q;
	logic [BLK_W-1:0] watch_d_q;
	logic [REG_W-1:0] reg_sel;
	logic             wr_en;
	logic [FS_W-1:0]  blk_x;
	logic             in_range;
	logic             watch_match;
	logic             req_known;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= FIRST_RST;
			fs_size_q <= FS_SIZE_RST;
			watch_a_q <= '0;
			watch_b_q <= '0;
			watch_c_q <= '0;
			watch_d_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FIRST:   first_q   <= pwdata[BLK_W-1:0];
				REG_FS_SIZE: fs_size_q <= pwdata[FS_W-1:0];
				REG_WATCH_A: watch_a_q <= pwdata[BLK_W-1:0];
				REG_WATCH_B: watch_b_q <= pwdata[BLK_W-1:0];
				REG_WATCH_C: watch_c_q <= pwdata[BLK_W-1:0];
				REG_WATCH_D: watch_d_q <= pwdata[BLK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_FIRST:   prdata = DATA_W'(first_q);
			REG_FS_SIZE: prdata = DATA_W'(fs_size_q);
			REG_WATCH_A: prdata = DATA_W'(watch_a_q);
			REG_WATCH_B: prdata = DATA_W'(watch_b_q);
			REG_WATCH_C: prdata = DATA_W'(watch_c_q);
			REG_WATCH_D: prdata = DATA_W'(watch_d_q);
			default:     prdata = '0;
		endcase
	end

	// data area is first_data_block up to the smaller of fs_size and the map size
	assign blk_x    = FS_W'(block_number);
	assign in_range = (blk_x >= FS_W'(first_q)) && (blk_x < fs_size_q) && (blk_x < BLK_LIMIT);

	assign watch_match = (watch_a_q != '0 && block_number == watch_a_q) ||
	                     (watch_b_q != '0 && block_number == watch_b_q) ||
	                     (watch_c_q != '0 && block_number == watch_c_q) ||
	                     (watch_d_q != '0 && block_number == watch_d_q);

	// the unused selector is taken and dropped
	assign req_known = (req_type == REQ_CHECK) || (req_type == REQ_SWEEP) ||
	                   (req_type == REQ_CLEAR);

	assign in_stall = q_full || init_busy;
	assign q_push   = in_valid && !in_stall && req_known;

	assign q_item.req      = req_type;
	assign q_item.blk      = block_number;
	assign q_item.inode    = from_inode;
	assign q_item.in_range = in_range;
	assign q_item.hit      = in_range && watch_match;

	assign cfg.first_data_block = first_q;
	assign cfg.fs_size          = fs_size_q;

endmodule

// ===== rtl/core/bdc_queue.sv =====
// short request queue between the front and back ends
module bdc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bdc_pkg::item_t push_item,
	input  logic           pop,
	output bdc_pkg::item_t pop_item,
	output logic           full,
	output logic           empty
);
	import bdc_pkg::*;

	item_t          slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full     = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");

endmodule

// ===== rtl/core/bdc_back.sv =====
// back end: block map memory, check read-modify-write, sweep count, clear pass
module bdc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bdc_pkg::cfg_t              cfg,
	input  bdc_pkg::item_t             q_item,
	input  logic                       q_empty,
	output logic                       q_pop,
	output logic                       init_busy,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic                       watch_hit,
	output logic [bdc_pkg::CNT_W-1:0]  dup_total,
	output logic [bdc_pkg::CNT_W-1:0]  used_refs,
	output logic [bdc_pkg::CNT_W-1:0]  marked_count,
	output logic                       all_accounted
);
	import bdc_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_SWEEP,
		S_CLEAR
	} state_t;

	localparam logic [ROW_AW:0] IDX_END  = (ROW_AW+1)'(ROWS);
	localparam logic [ROW_AW:0] IDX_LAST = (ROW_AW+1)'(ROWS - 1);

	state_t               state_q;
	logic [ROW_AW:0]      idx_q;
	logic [BLK_W-1:0]     blk_q;
	logic                 hit_q;
	logic                 v_s1_q;
	logic                 v_s2_q;
	logic [ROW_AW-1:0]    row_s1;
	logic [BIT_AW:0]      pc_s2;
	logic [SUM_W-1:0]     acc_q;
	logic [CNT_W-1:0]     dup_q;
	logic [CNT_W-1:0]     used_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic                 hit_out_q;
	logic [CNT_W-1:0]     dup_out_q;
	logic [CNT_W-1:0]     used_out_q;
	logic [CNT_W-1:0]     marked_q;
	logic                 accounted_q;

	logic [ROW_BITS-1:0]  map_mem [ROWS];
	logic [ROW_BITS-1:0]  rd_row_q;
	logic                 rd_en;
	logic [ROW_AW-1:0]    rd_addr;
	logic                 wr_en;
	logic [ROW_AW-1:0]    wr_addr;
	logic [ROW_BITS-1:0]  wr_data;

	logic                 out_free;
	logic                 sweep_issue;
	logic                 sweep_done;
	logic                 clear_last;
	logic                 oor_now;
	logic                 res_load;
	logic                 dup_bit;
	logic [CNT_W-1:0]     used_nx;
	logic [FS_W-1:0]      end_blk;
	logic [FS_W-1:0]      row_x;
	logic [FS_W-1:0]      first_row;
	logic [FS_W-1:0]      end_row;
	logic [ROW_BITS-1:0]  lo_mask;
	logic [ROW_BITS-1:0]  hi_mask;
	logic [FS_W-1:0]      acc_x;
	logic [FS_W-1:0]      first_x;
	logic [CNT_W-1:0]     marked_nx;
	logic                 accounted_nx;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_SAT) ? v : v + 1'b1;
	endfunction

	// map storage, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_row_q <= map_mem[rd_addr];
		end
	end

	assign out_free    = !out_valid_q || !out_stall;
	assign q_pop       = (state_q == S_IDLE) && !q_empty && out_free;
	assign oor_now     = q_pop && (q_item.req == REQ_CHECK) && !q_item.in_range;
	assign sweep_issue = (state_q == S_SWEEP) && (idx_q != IDX_END);
	assign sweep_done  = (state_q == S_SWEEP) && (idx_q == IDX_END) && !v_s1_q && !v_s2_q;
	assign clear_last  = (state_q == S_CLEAR) && (idx_q == IDX_LAST);
	assign res_load    = oor_now || (state_q == S_CHECK) || sweep_done || clear_last;
	assign init_busy   = (state_q == S_INIT);
	assign used_nx     = q_item.inode ? sat_inc(used_q) : used_q;
	assign dup_bit     = rd_row_q[blk_q[BIT_AW-1:0]];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[ROW_AW-1:0];
		if (q_pop && q_item.req == REQ_CHECK && q_item.in_range) begin
			rd_en   = 1'b1;
			rd_addr = q_item.blk[BIT_AW +: ROW_AW];
		end else if (sweep_issue) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[ROW_AW-1:0];
		wr_data = '0;
		if (state_q == S_CHECK) begin
			wr_en   = 1'b1;
			wr_addr = blk_q[BIT_AW +: ROW_AW];
			wr_data = rd_row_q | (ROW_BITS'(1) << blk_q[BIT_AW-1:0]);
		end else if (state_q == S_INIT || state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end
	end

	// per-row mask of the data area for the sweep
	assign end_blk   = (cfg.fs_size < BLK_LIMIT) ? cfg.fs_size : BLK_LIMIT;
	assign first_x   = FS_W'(cfg.first_data_block);
	assign row_x     = FS_W'(row_s1);
	assign first_row = first_x >> BIT_AW;
	assign end_row   = end_blk >> BIT_AW;

	always_comb begin
		if (row_x < first_row) begin
			lo_mask = '0;
		end else if (row_x == first_row) begin
			lo_mask = '1 << first_x[BIT_AW-1:0];
		end else begin
			lo_mask = '1;
		end
		if (row_x < end_row) begin
			hi_mask = '1;
		end else if (row_x == end_row) begin
			hi_mask = ~('1 << end_blk[BIT_AW-1:0]);
		end else begin
			hi_mask = '0;
		end
	end

	assign acc_x        = FS_W'(acc_q);
	assign marked_nx    = (acc_x > FS_W'(CNT_SAT)) ? CNT_SAT : acc_x[CNT_W-1:0];
	assign accounted_nx = (cfg.fs_size >= first_x) && (acc_x == cfg.fs_size - first_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			idx_q       <= '0;
			blk_q       <= '0;
			hit_q       <= 1'b0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			row_s1      <= '0;
			pc_s2       <= '0;
			acc_q       <= '0;
			dup_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			hit_out_q   <= 1'b0;
			dup_out_q   <= '0;
			used_out_q  <= '0;
			marked_q    <= '0;
			accounted_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						unique case (q_item.req)
							REQ_CHECK: begin
								used_q <= used_nx;
								blk_q  <= q_item.blk;
								hit_q  <= q_item.hit;
								if (q_item.in_range) begin
									state_q <= S_CHECK;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= STAT_OOR;
									hit_out_q   <= 1'b0;
									dup_out_q   <= dup_q;
									used_out_q  <= used_nx;
									marked_q    <= '0;
									accounted_q <= 1'b0;
								end
							end
							REQ_SWEEP: begin
								idx_q   <= '0;
								acc_q   <= '0;
								v_s1_q  <= 1'b0;
								v_s2_q  <= 1'b0;
								state_q <= S_SWEEP;
							end
							REQ_CLEAR: begin
								idx_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					out_valid_q <= 1'b1;
					status_q    <= dup_bit ? STAT_DUP : STAT_OK;
					hit_out_q   <= hit_q;
					dup_out_q   <= dup_bit ? sat_inc(dup_q) : dup_q;
					used_out_q  <= used_q;
					marked_q    <= '0;
					accounted_q <= 1'b0;
					if (dup_bit) begin
						dup_q <= sat_inc(dup_q);
					end
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					if (sweep_issue) begin
						idx_q <= idx_q + 1'b1;
					end
					v_s1_q <= sweep_issue;
					v_s2_q <= v_s1_q;
					row_s1 <= idx_q[ROW_AW-1:0];
					pc_s2  <= (BIT_AW+1)'($countones(rd_row_q & lo_mask & hi_mask));
					if (v_s2_q) begin
						acc_q <= acc_q + SUM_W'(pc_s2);
					end
					if (sweep_done) begin
						out_valid_q <= 1'b1;
						status_q    <= STAT_DONE;
						hit_out_q   <= 1'b0;
						dup_out_q   <= dup_q;
						used_out_q  <= used_q;
						marked_q    <= marked_nx;
						accounted_q <= accounted_nx;
						state_q     <= S_IDLE;
					end
				end
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (clear_last) begin
						dup_q       <= '0;
						used_q      <= '0;
						out_valid_q <= 1'b1;
						status_q    <= STAT_DONE;
						hit_out_q   <= 1'b0;
						dup_out_q   <= '0;
						used_out_q  <= '0;
						marked_q    <= '0;
						accounted_q <= 1'b0;
						idx_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign watch_hit     = hit_out_q;
	assign dup_total     = dup_out_q;
	assign used_refs     = used_out_q;
	assign marked_count  = marked_q;
	assign all_accounted = accounted_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE)) else $error("queue popped outside idle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free) else $error("result loaded over a waiting beat");

	a_stage_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q) |-> (state_q == S_SWEEP)) else $error("sweep stage live outside sweep");

	a_dup_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (dup_q >= $past(dup_q))) else $error("dup count fell without clear");

endmodule

// ===== rtl/core/block_duplicate_checker.sv =====
// top level of the block duplicate checker
// The checker keeps a one-bit-per-block map of filesystem blocks and takes one request beat at a
// time: a check marks a block and reports out of range, duplicate or ok together with a watch hit
// and the running duplicate and inode-reference counts; a sweep counts marked data blocks; a clear
// empties the map and counters. Every request other than the unused selector gives one result
// beat. The map is a 2048 x 32-bit memory with one read and one write port, and that port pair
// sets the timing: a check of an in-range block reads the row, then writes it back; an
// out-of-range check is answered without a map access; a sweep reads one map row per cycle into a
// two-stage count pipeline; and a clear writes one row per cycle. After reset the map is wiped
// by a clearing pass during which in_stall stays high; register writes are taken throughout. A
// four-entry request queue lets requests be taken while the back end works and a finished result
// waits in the output register. Registers sit at byte address 4*i in the order first_data_block,
// fs_size, watch_block_a..d; the user must write them only while the block is idle (not enforced).
module block_duplicate_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bdc_pkg::DATA_W-1:0]  pwdata,
	output logic [bdc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// request beat
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [bdc_pkg::BLK_W-1:0]   block_number,
	input  logic                        from_inode,
	// result beat
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic                        watch_hit,
	output logic [bdc_pkg::CNT_W-1:0]   dup_total,
	output logic [bdc_pkg::CNT_W-1:0]   used_refs,
	output logic [bdc_pkg::CNT_W-1:0]   marked_count,
	output logic                        all_accounted
);
	import bdc_pkg::*;

	// classified requests from front to back
	item_t push_item;
	item_t pop_item;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	// range settings and the back end's wipe status
	cfg_t  cfg;
	logic  init_busy;

	// registers, range and watch compare, request drop for the unused selector
	bdc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.block_number (block_number),
		.from_inode   (from_inode),
		.q_full       (q_full),
		.init_busy    (init_busy),
		.q_push       (q_push),
		.q_item       (push_item),
		.cfg          (cfg)
	);

	// decouples request intake from the map work
	bdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// map memory, counters and the result register
	bdc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_item        (pop_item),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.init_busy     (init_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.watch_hit     (watch_hit),
		.dup_total     (dup_total),
		.used_refs     (used_refs),
		.marked_count  (marked_count),
		.all_accounted (all_accounted)
	);

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the block duplicate checker
module testbench;
	import bdc_pkg::*;

	// request selector that the block ignores, and register indexes past the last one
	localparam logic [1:0]       REQ_UNUSED  = 2'd3;
	localparam logic [REG_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_W-1:0] REG_SPARE_B = 3'd7;

	// cycles to let the block settle once the last result is in (ignored beats, queue)
	localparam int SETTLE_CYCLES = 32;
	localparam int MAX_PRINTED   = 50;
	localparam int PHASE_ITEMS   = 215;
	localparam int RECENT_DEPTH  = 32;
	// size of the small data area that gets filled completely
	localparam int FULL_SPAN     = 40;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one result beat as the block should produce it
	typedef struct {
		logic [1:0]       status;
		logic             watch_hit;
		logic [CNT_W-1:0] dup_total;
		logic [CNT_W-1:0] used_refs;
		logic [CNT_W-1:0] marked_count;
		logic             all_accounted;
	} block_result_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [ADDR_W-1:0] paddr         = '0;
	logic [DATA_W-1:0] pwdata        = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type      = REQ_CHECK;
	logic [BLK_W-1:0]  block_number  = '0;
	logic              from_inode    = 1'b0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [1:0]        status;
	logic              watch_hit;
	logic [CNT_W-1:0]  dup_total;
	logic [CNT_W-1:0]  used_refs;
	logic [CNT_W-1:0]  marked_count;
	logic              all_accounted;

	// own copy of the block: settings, map and counters
	int unsigned      first_blk;
	int unsigned      fs_blocks;
	logic [BLK_W-1:0] watch_regs [4];
	bit               block_map [MAX_BLOCKS];
	logic [CNT_W-1:0] dup_ctr;
	logic [CNT_W-1:0] used_ctr;

	block_result_t    expected_results [$];
	logic [BLK_W-1:0] recent_blocks [$];
	int               mismatches    = 0;
	int               send_idle_pct = 0;
	int               stall_pct     = 0;

	block_duplicate_checker DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.block_number(block_number), .from_inode(from_inode),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.watch_hit(watch_hit), .dup_total(dup_total), .used_refs(used_refs),
		.marked_count(marked_count), .all_accounted(all_accounted)
	);

	always #5 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t: %s got %h expected %h", $time, what, got, want);
	endtask

	function automatic bit is_watched(input logic [BLK_W-1:0] blk);
		for (int k = 0; k < 4; k++)
			if (watch_regs[k] != '0 && blk == watch_regs[k])
				return 1'b1;
		return 1'b0;
	endfunction

	// applies one accepted request beat to the local map and queues its result
	function automatic void account_request(input logic [1:0] req,
			input logic [BLK_W-1:0] blk, input logic inode);
		block_result_t res;
		int unsigned   span_end;
		int unsigned   count;
		res = '{default: '0};
		case (req)
			REQ_CHECK: begin
				// inode references count even for rejected blocks
				if (inode && used_ctr != CNT_SAT)
					used_ctr++;
				if (blk < first_blk || blk >= fs_blocks || blk >= MAX_BLOCKS) begin
					res.status = STAT_OOR;
				end else begin
					res.status = STAT_OK;
					if (block_map[blk]) begin
						res.status = STAT_DUP;
						if (dup_ctr != CNT_SAT)
							dup_ctr++;
					end
					res.watch_hit = is_watched(blk);
					block_map[blk] = 1'b1;
				end
			end
			REQ_SWEEP: begin
				span_end = (fs_blocks < MAX_BLOCKS) ? fs_blocks : MAX_BLOCKS;
				count = 0;
				for (int unsigned i = first_blk; i < span_end; i++)
					if (block_map[i])
						count++;
				res.status = STAT_DONE;
				res.marked_count = (count > CNT_SAT) ? CNT_SAT : count[CNT_W-1:0];
				// the full-count compare uses the unsaturated count
				res.all_accounted = (fs_blocks >= first_blk) &&
					(count == fs_blocks - first_blk);
			end
			REQ_CLEAR: begin
				foreach (block_map[i])
					block_map[i] = 1'b0;
				dup_ctr = '0;
				used_ctr = '0;
				res.status = STAT_DONE;
			end
			default: return;
		endcase
		res.dup_total = dup_ctr;
		res.used_refs = used_ctr;
		expected_results.push_back(res);
	endfunction

	// result checker: a beat is taken at the next rising edge when valid and not stalled
	always @(negedge clk) begin
		block_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(status), '0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (watch_hit !== want.watch_hit)
					report_mismatch("watch_hit", 32'(watch_hit), 32'(want.watch_hit));
				if (dup_total !== want.dup_total)
					report_mismatch("dup_total", 32'(dup_total), 32'(want.dup_total));
				if (used_refs !== want.used_refs)
					report_mismatch("used_refs", 32'(used_refs), 32'(want.used_refs));
				if (marked_count !== want.marked_count)
					report_mismatch("marked_count", 32'(marked_count),
						32'(want.marked_count));
				if (all_accounted !== want.all_accounted)
					report_mismatch("all_accounted", 32'(all_accounted),
						32'(want.all_accounted));
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER) ? 50 : (mode == IDLE_BOTH) ? 14 : 0;
		stall_pct     = (mode == IDLE_RECEIVER) ? 50 : (mode == IDLE_BOTH) ? 14 : 0;
	endtask

	// sends one request beat; called and returning at a rising edge
	task automatic send_request(input logic [1:0] req, input logic [BLK_W-1:0] blk,
			input logic inode);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= req;
		block_number <= blk;
		from_inode   <= inode;
		do @(negedge clk); while (in_stall);
		account_request(req, blk, inode);
		@(posedge clk);
	endtask

	// holds the sender off until every queued result has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic reg_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_read(input logic [REG_W-1:0] idx, output logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		value = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// writes all six registers while the block is idle, then reads them back
	task automatic set_config(input int unsigned first, input int unsigned fs,
			input int unsigned wa, input int unsigned wb, input int unsigned wc,
			input int unsigned wd);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] want [6];
		logic [REG_W-1:0]  idx;
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		first_blk     = first & 32'hFFFF;
		fs_blocks     = fs & 32'h1FFFF;
		watch_regs[0] = wa[BLK_W-1:0];
		watch_regs[1] = wb[BLK_W-1:0];
		watch_regs[2] = wc[BLK_W-1:0];
		watch_regs[3] = wd[BLK_W-1:0];
		want[REG_FIRST]   = first_blk;
		want[REG_FS_SIZE] = fs_blocks;
		want[REG_WATCH_A] = DATA_W'(watch_regs[0]);
		want[REG_WATCH_B] = DATA_W'(watch_regs[1]);
		want[REG_WATCH_C] = DATA_W'(watch_regs[2]);
		want[REG_WATCH_D] = DATA_W'(watch_regs[3]);
		for (int i = 0; i < 6; i++) begin
			idx = REG_W'(i);
			reg_write(idx, want[i]);
		end
		for (int i = 0; i < 6; i++) begin
			idx = REG_W'(i);
			reg_read(idx, rd);
			if (rd !== want[i])
				report_mismatch($sformatf("register %0d readback", i), rd, want[i]);
		end
	endtask

	// picks a block number: mostly inside the data area, with repeats, watches and edges
	function automatic logic [BLK_W-1:0] pick_block();
		int unsigned lo;
		int unsigned hi;
		int unsigned sel;
		lo  = first_blk;
		hi  = (fs_blocks < MAX_BLOCKS) ? fs_blocks : MAX_BLOCKS;
		sel = $urandom_range(99);
		if (sel < 15)
			return BLK_W'($urandom);
		if (sel < 25) begin
			case ($urandom_range(3))
				0: return BLK_W'(lo - 1);
				1: return BLK_W'(lo);
				2: return BLK_W'(hi - 1);
				default: return BLK_W'(hi);
			endcase
		end
		if (sel < 45 && recent_blocks.size() != 0)
			return recent_blocks[$urandom_range(recent_blocks.size() - 1)];
		if (sel < 52)
			return watch_regs[$urandom_range(3)];
		if (hi <= lo)
			return BLK_W'($urandom);
		return BLK_W'(lo + $urandom_range(hi - lo - 1));
	endfunction

	task automatic run_random_phase(input int items);
		int               sent;
		int               sel;
		bit               paused;
		logic [BLK_W-1:0] blk;
		sent   = 0;
		paused = 1'b0;
		while (sent < items) begin
			// one pause mid-phase until everything queued has come back
			if (!paused && sent == items / 2) begin
				wait_results_drained();
				paused = 1'b1;
			end
			sel = $urandom_range(199);
			if (sel < 4) begin
				send_request(REQ_SWEEP, BLK_W'($urandom), 1'($urandom));
				sent++;
			end else if (sel < 6) begin
				send_request(REQ_CLEAR, BLK_W'($urandom), 1'($urandom));
				sent++;
			end else if (sel < 12) begin
				// ignored beats do not count toward the phase
				send_request(REQ_UNUSED, BLK_W'($urandom), 1'($urandom));
			end else begin
				blk = pick_block();
				send_request(REQ_CHECK, blk, 1'($urandom));
				recent_blocks.push_back(blk);
				if (recent_blocks.size() > RECENT_DEPTH)
					void'(recent_blocks.pop_front());
				sent++;
			end
		end
	endtask

	// extremes of the fields, each request kind, watches, duplicates, ignored selector
	task automatic test_directed();
		set_idling(IDLE_NONE);
		set_config(32'(FIRST_RST), 32'(FS_SIZE_RST), 1, 2, 32'hFFFF, 0);
		// writes past the last register must change nothing
		reg_write(REG_SPARE_A, '1);
		reg_write(REG_SPARE_B, '1);
		send_request(REQ_CHECK, 16'd0, 1'b1);
		send_request(REQ_CHECK, 16'd1, 1'b1);
		send_request(REQ_CHECK, 16'd2, 1'b1);
		send_request(REQ_CHECK, 16'd2, 1'b0);
		send_request(REQ_CHECK, 16'hFFFF, 1'b1);
		send_request(REQ_CHECK, 16'hFFFF, 1'b0);
		send_request(REQ_CHECK, 16'h5555, 1'b0);
		send_request(REQ_CHECK, 16'hAAAA, 1'b1);
		send_request(REQ_UNUSED, 16'h1234, 1'b1);
		send_request(REQ_SWEEP, 16'hFFFF, 1'b1);
		send_request(REQ_CLEAR, 16'h0000, 1'b0);
		send_request(REQ_SWEEP, 16'h0000, 1'b0);
		send_request(REQ_CHECK, 16'd3, 1'b1);
	endtask

	// empty data area, area below zero size, single-block areas at both ends
	task automatic test_data_area_edges();
		set_idling(IDLE_BOTH);
		set_config(100, 100, 0, 0, 0, 0);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
		send_request(REQ_CHECK, 16'd100, 1'b1);
		set_config(200, 0, 0, 0, 0, 0);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
		send_request(REQ_CHECK, 16'd0, 1'b0);
		// block 0 in range with all watches unused
		set_config(0, 1, 0, 0, 0, 0);
		send_request(REQ_CHECK, 16'd0, 1'b1);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
		set_config(32'hFFFF, MAX_BLOCKS, 32'hFFFF, 0, 0, 0);
		send_request(REQ_CHECK, 16'hFFFF, 1'b0);
		send_request(REQ_CHECK, 16'hFFFE, 1'b0);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
	endtask

	// several settings, each run under one of the idling patterns
	task automatic test_random();
		int unsigned first;
		set_idling(IDLE_NONE);
		set_config(32'(FIRST_RST), 32'(FS_SIZE_RST), 0, 0, 0, 0);
		run_random_phase(PHASE_ITEMS);
		set_idling(IDLE_SENDER);
		set_config(0, 300, 5, 0, 299, 32'hFFFF);
		run_random_phase(PHASE_ITEMS);
		set_idling(IDLE_RECEIVER);
		set_config(32'hFFF0, MAX_BLOCKS, 32'hFFFF, 32'hFFF0, 0, 32'hFFF8);
		run_random_phase(PHASE_ITEMS);
		set_idling(IDLE_BOTH);
		set_config(1000, 5000, $urandom_range(1000, 4999), $urandom_range(1000, 4999),
			$urandom, 0);
		run_random_phase(PHASE_ITEMS);
		set_idling(IDLE_NONE);
		set_config(4000, 3000, 3500, 0, 0, 0);
		run_random_phase(PHASE_ITEMS / 2);
		for (int p = 0; p < 3; p++) begin
			set_idling(idle_mode_t'(p + 1));
			first = $urandom_range(0, 8000);
			set_config(first, first + $urandom_range(0, 4000), first + $urandom_range(0, 400),
				$urandom, first + $urandom_range(0, 400), $urandom_range(0, 1));
			run_random_phase(PHASE_ITEMS);
		end
	endtask

	// fills a small data area at the top of the map and sweeps it full, short and long
	task automatic test_full_area();
		set_idling(IDLE_NONE);
		set_config(MAX_BLOCKS - FULL_SPAN, MAX_BLOCKS, 0, 0, 0, 0);
		send_request(REQ_CLEAR, 16'd0, 1'b0);
		for (int b = MAX_BLOCKS - FULL_SPAN; b < MAX_BLOCKS; b++)
			send_request(REQ_CHECK, b[BLK_W-1:0], 1'b1);
		// every data block marked
		send_request(REQ_SWEEP, 16'd0, 1'b0);
		// area one block shorter, still fully marked
		set_config(MAX_BLOCKS - FULL_SPAN, MAX_BLOCKS - 1, 0, 0, 0, 0);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
		// area one block longer, one block unmarked
		set_config(MAX_BLOCKS - FULL_SPAN - 1, MAX_BLOCKS, 0, 0, 0, 0);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
		send_request(REQ_CLEAR, 16'd0, 1'b0);
		send_request(REQ_SWEEP, 16'd0, 1'b0);
	endtask

	initial begin
		// local copy starts from the reset state of the block
		first_blk = 32'(FIRST_RST);
		fs_blocks = 32'(FS_SIZE_RST);
		foreach (watch_regs[k])
			watch_regs[k] = '0;
		foreach (block_map[i])
			block_map[i] = 1'b0;
		dup_ctr  = '0;
		used_ctr = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// the clearing pass after reset holds in_stall; the handshake waits it out
		test_directed();
		test_data_area_edges();
		test_random();
		test_full_area();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// generous bound on the run time
	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
